>>> design/tcpm_pkg.sv
// ----------------------------------------------------------------------------
// tcpm_pkg: shared types and constants of the threshold crossing period meter
// Holds the widths, the controller states and the command and status structs.
// ----------------------------------------------------------------------------
package tcpm_pkg;

   localparam int TimeWidth  = 48;
   localparam int ValWidth   = 32;
   localparam int FracWidth  = 32;
   localparam int NumState   = 5;
   localparam int NumAux     = NumState - 1;
   localparam int DivCntWidth = $clog2(FracWidth + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;       // capture a new sample and run the crossing check
      logic div_step;   // one restoring divide step
      logic mul;        // register partial products
      logic acc;        // form interpolated results
      logic commit;     // update history and last crossing time
   } cmd_type;

   typedef struct packed {
      logic crossing;   // registered crossing flag of the captured sample
      logic div_done;
   } status_type;

endpackage

>>> design/threshold_crossing_period_meter_top.sv
// ----------------------------------------------------------------------------
// threshold_crossing_period_meter_top: upward crossing detector and period meter
// Interpolates crossing time and auxiliary values, reports crossing period.
// ----------------------------------------------------------------------------
// One sample is taken per beat; the next waits until the current one is
// retired. A sample with no crossing (or a first-step sample) is retired
// after the crossing check and yields no result beat. A crossing runs a
// one-bit-per-cycle restoring divider that forms the Q0.32 interpolation
// fraction, then products, accumulate/saturate, the output held until taken.
// The threshold is written through csr_write_enable/csr_write_data and
// should be written only while the block is idle.
module threshold_crossing_period_meter_top
   import tcpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic signed [31:0]         csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_first_step,
   input  logic [47:0]                req_sample_time,
   input  logic signed [31:0]         req_lead_value,
   input  logic signed [31:0]         req_aux_zero,
   input  logic signed [31:0]         req_aux_one,
   input  logic signed [31:0]         req_aux_two,
   input  logic signed [31:0]         req_aux_three,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [47:0]                rsp_crossing_time,
   output logic [47:0]                rsp_crossing_period,
   output logic signed [31:0]         rsp_aux_at_cross_zero,
   output logic signed [31:0]         rsp_aux_at_cross_one,
   output logic signed [31:0]         rsp_aux_at_cross_two,
   output logic signed [31:0]         rsp_aux_at_cross_three
);

   cmd_type    cmd;
   status_type status;

   // auxiliary inputs in use, in channel order
   logic signed [ValWidth-1:0] aux_all [4];
   logic signed [ValWidth-1:0] aux_in  [NumAux];
   logic signed [ValWidth-1:0] aux_out [4];

   assign aux_all[0] = req_aux_zero;
   assign aux_all[1] = req_aux_one;
   assign aux_all[2] = req_aux_two;
   assign aux_all[3] = req_aux_three;

   always_comb begin
      for (int i = 0; i < NumAux; i++) aux_in[i] = aux_all[i];
   end

   tcpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcpm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .cmd                 (cmd),
      .status              (status),
      .req_first_step      (req_first_step),
      .req_sample_time     (req_sample_time),
      .req_lead_value      (req_lead_value),
      .req_aux             (aux_in),
      .rsp_crossing_time   (rsp_crossing_time),
      .rsp_crossing_period (rsp_crossing_period),
      .rsp_aux             (aux_out)
   );

   // unused channels read zero
   assign rsp_aux_at_cross_zero  = aux_out[0];
   assign rsp_aux_at_cross_one   = aux_out[1];
   assign rsp_aux_at_cross_two   = aux_out[2];
   assign rsp_aux_at_cross_three = aux_out[3];

endmodule

>>> design/tcpm_ctrl.sv
// ----------------------------------------------------------------------------
// tcpm_ctrl: sequencer of the threshold crossing period meter
// Steps the datapath through capture, division, products and output.
// ----------------------------------------------------------------------------
module tcpm_ctrl
   import tcpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!status.crossing) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.div_done) begin
               state_in = ST_MUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> design/tcpm_datapath.sv
// ----------------------------------------------------------------------------
// tcpm_datapath: arithmetic of the threshold crossing period meter
// History registers, a serial divider and the interpolation products.
// ----------------------------------------------------------------------------
module tcpm_datapath
   import tcpm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic signed [ValWidth-1:0]  csr_write_data,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic                        req_first_step,
   input  logic [TimeWidth-1:0]        req_sample_time,
   input  logic signed [ValWidth-1:0]  req_lead_value,
   input  logic signed [ValWidth-1:0]  req_aux [NumAux],
   output logic [TimeWidth-1:0]        rsp_crossing_time,
   output logic [TimeWidth-1:0]        rsp_crossing_period,
   output logic signed [ValWidth-1:0]  rsp_aux [4]
);

   localparam int DW = ValWidth + 1;   // differences of two values

   logic signed [ValWidth-1:0] threshold_ff;
   logic [TimeWidth-1:0]       prev_time_ff, last_cross_ff, time_ff;
   logic signed [ValWidth-1:0] prev_lead_ff, lead_ff;
   logic signed [ValWidth-1:0] prev_aux_ff [NumAux];
   logic signed [ValWidth-1:0] aux_ff [NumAux];
   logic                       cross_ff;

   // divider: remainder, divisor, quotient, step count
   logic [DW:0]               rem_ff;
   logic [DW-1:0]             den_ff;
   logic [FracWidth-1:0]      quo_ff;
   logic [DivCntWidth-1:0]    cnt_ff;

   // products
   logic [TimeWidth-1:0]      dt;
   logic [63:0]               phi_ff, plo_ff;
   logic [DW+FracWidth-1:0]   pa_ff [NumAux];
   logic                      neg_ff [NumAux];

   logic [TimeWidth-1:0]      tc_ff, per_ff;
   logic signed [ValWidth-1:0] ra_ff [NumAux];

   logic signed [DW-1:0] num_w, den_w;
   assign num_w = DW'(threshold_ff) - DW'(prev_lead_ff);
   assign den_w = DW'(req_lead_value) - DW'(prev_lead_ff);

   assign dt = (time_ff >= prev_time_ff) ? time_ff - prev_time_ff : '0;

   logic [DW:0] rem_sh;
   assign rem_sh = {rem_ff[DW-1:0], 1'b0};

   assign status.crossing = cross_ff;
   assign status.div_done = (cnt_ff == DivCntWidth'(FracWidth));

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         prev_time_ff  <= '0;
         prev_lead_ff  <= '0;
         last_cross_ff <= '0;
         cross_ff      <= 1'b0;
         for (int i = 0; i < NumAux; i++) prev_aux_ff[i] <= '0;
      end else begin
         if (csr_write_enable) threshold_ff <= csr_write_data;
         if (cmd.load) begin
            cross_ff <= !req_first_step && (prev_lead_ff < threshold_ff)
                        && (req_lead_value > threshold_ff);
         end
         if (cmd.commit) begin
            prev_time_ff <= time_ff;
            prev_lead_ff <= lead_ff;
            for (int i = 0; i < NumAux; i++) prev_aux_ff[i] <= aux_ff[i];
            if (cross_ff) last_cross_ff <= tc_ff;
            cross_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff <= req_sample_time;
         lead_ff <= req_lead_value;
         for (int i = 0; i < NumAux; i++) aux_ff[i] <= req_aux[i];
         // num < den, so the quotient of num*2^32/den fits 32 bits
         rem_ff <= {1'b0, num_w};
         den_ff <= den_w;
         quo_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            quo_ff <= {quo_ff[FracWidth-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[FracWidth-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.mul) begin
         phi_ff <= 64'(dt[TimeWidth-1:16]) * 64'(quo_ff);
         plo_ff <= 64'(dt[15:0]) * 64'(quo_ff);
         for (int i = 0; i < NumAux; i++) begin
            logic signed [DW-1:0] d;
            logic [DW-1:0]        m;
            d = DW'(aux_ff[i]) - DW'(prev_aux_ff[i]);
            m = d[DW-1] ? DW'(-d) : DW'(d);
            neg_ff[i] <= d[DW-1];
            pa_ff[i]  <= (DW+FracWidth)'(m) * (DW+FracWidth)'(quo_ff);
         end
      end
      if (cmd.acc) begin
         logic [TimeWidth-1:0] tc;
         tc = prev_time_ff + TimeWidth'((phi_ff + (plo_ff >> 16)) >> 16);
         tc_ff  <= tc;
         per_ff <= (tc >= last_cross_ff) ? tc - last_cross_ff : '0;
         for (int i = 0; i < NumAux; i++) begin
            logic [DW-1:0]        q;
            logic signed [DW+1:0] r;
            q = pa_ff[i][DW+FracWidth-1:FracWidth];
            if (neg_ff[i] && (pa_ff[i][FracWidth-1:0] != '0)) q = q + 1'b1;
            r = (DW+2)'(prev_aux_ff[i])
                + (neg_ff[i] ? -(DW+2)'(q) : (DW+2)'(q));
            if (r > (DW+2)'(32'sh7fffffff))       ra_ff[i] <= 32'sh7fffffff;
            else if (r < -(DW+2)'(33'sh80000000)) ra_ff[i] <= 32'sh80000000;
            else                                   ra_ff[i] <= r[ValWidth-1:0];
         end
      end
   end

   assign rsp_crossing_time   = tc_ff;
   assign rsp_crossing_period = per_ff;
   always_comb begin
      for (int i = 0; i < 4; i++) rsp_aux[i] = '0;
      for (int i = 0; i < NumAux; i++) rsp_aux[i] = ra_ff[i];
   end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the threshold crossing period meter
// Drives time-stamped samples, predicts interpolated crossings and compares
// every response beat field by field under varying threshold and idling.
// ----------------------------------------------------------------------------
module tb_top;
   import tcpm_pkg::*;

   typedef struct {
      logic               first_step;
      logic [47:0]        sample_time;
      logic signed [31:0] lead_value;
      logic signed [31:0] aux [4];
   } sample_type;

   typedef struct {
      logic [47:0]        crossing_time;
      logic [47:0]        crossing_period;
      logic signed [31:0] aux [4];
   } crossing_type;

   // idling profiles, percent of cycles
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_profile_type;

   localparam int  LimitCycles = 1000000;
   localparam int  DrainCycles = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic signed [31:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_first_step = 1'b0;
   logic [47:0] req_sample_time = '0;
   logic signed [31:0] req_lead_value = '0;
   logic signed [31:0] req_aux_zero = '0;
   logic signed [31:0] req_aux_one = '0;
   logic signed [31:0] req_aux_two = '0;
   logic signed [31:0] req_aux_three = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [47:0] rsp_crossing_time;
   logic [47:0] rsp_crossing_period;
   logic signed [31:0] rsp_aux_at_cross_zero;
   logic signed [31:0] rsp_aux_at_cross_one;
   logic signed [31:0] rsp_aux_at_cross_two;
   logic signed [31:0] rsp_aux_at_cross_three;

   always #4 clock = ~clock;

   threshold_crossing_period_meter_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_first_step         (req_first_step),
      .req_sample_time        (req_sample_time),
      .req_lead_value         (req_lead_value),
      .req_aux_zero           (req_aux_zero),
      .req_aux_one            (req_aux_one),
      .req_aux_two            (req_aux_two),
      .req_aux_three          (req_aux_three),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_crossing_time      (rsp_crossing_time),
      .rsp_crossing_period    (rsp_crossing_period),
      .rsp_aux_at_cross_zero  (rsp_aux_at_cross_zero),
      .rsp_aux_at_cross_one   (rsp_aux_at_cross_one),
      .rsp_aux_at_cross_two   (rsp_aux_at_cross_two),
      .rsp_aux_at_cross_three (rsp_aux_at_cross_three)
   );

   // ------------------------------------------------------------------------
   // crossing predictor: own copy of threshold and sample history
   // ------------------------------------------------------------------------
   logic signed [31:0] model_threshold;
   logic [47:0]        hist_time;
   logic signed [31:0] hist_lead;
   logic signed [31:0] hist_aux [4];
   logic [47:0]        hist_cross_time;

   sample_type   pending_samples [$];
   crossing_type expected_crossings [$];

   int  mismatch_count = 0;
   bit  failed = 1'b0;
   int  crossing_beats = 0;
   longint cycle_count = 0;

   idle_profile_type idle_profile = IDLE_NONE;
   int  hold_off_cycles = 0;    // long receiver stall when nonzero
   bit  sender_paused = 1'b0;

   // old + floor((new - old) * frac / 2^32), floored toward minus infinity
   function automatic logic signed [31:0] aux_at_fraction(
      logic signed [31:0] old_val, logic signed [31:0] new_val, logic [31:0] frac);
      logic signed [33:0] diff;
      logic signed [66:0] prod;
      logic signed [34:0] sum;
      diff = 34'(new_val) - 34'(old_val);
      prod = 67'(diff) * $signed({35'd0, frac});
      sum  = 35'(old_val) + 35'(prod >>> 32);
      if (sum > 35'sd2147483647) return 32'sh7fffffff;
      if (sum < -35'sd2147483648) return 32'sh80000000;
      return sum[31:0];
   endfunction

   task automatic predict_crossing(input sample_type s);
      crossing_type c;
      logic [64:0]  num, den;
      logic [31:0]  frac;
      logic [47:0]  dt;
      logic [79:0]  dt_prod;
      logic [47:0]  tc;
      if (!s.first_step && hist_lead < model_threshold && s.lead_value > model_threshold) begin
         num     = 65'(34'(model_threshold) - 34'(hist_lead));
         den     = 65'(34'(s.lead_value) - 34'(hist_lead));
         frac    = 32'((num << 32) / den);
         dt      = (s.sample_time >= hist_time) ? s.sample_time - hist_time : '0;
         dt_prod = 80'(dt) * 80'(frac);
         tc      = hist_time + 48'(dt_prod >> 32);
         c.crossing_time   = tc;
         c.crossing_period = (tc >= hist_cross_time) ? tc - hist_cross_time : '0;
         for (int i = 0; i < 4; i++) begin
            c.aux[i] = (i < NumAux) ? aux_at_fraction(hist_aux[i], s.aux[i], frac) : '0;
         end
         hist_cross_time = tc;
         expected_crossings.push_back(c);
      end
      hist_time = s.sample_time;
      hist_lead = s.lead_value;
      for (int i = 0; i < 4; i++) hist_aux[i] = s.aux[i];
   endtask

   function automatic bit sender_idles();
      case (idle_profile)
         IDLE_SENDER, IDLE_BOTH: begin
            return $urandom_range(99) < ((idle_profile == IDLE_SENDER) ? 46 : 17);
         end
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // driver: pops pending samples, holds payload until the beat is taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            // accepted sample goes through the predictor here, in beat order
            predict_crossing(pending_samples.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            // free to offer the next sample or idle; the head is the next one
            if (pending_samples.size() != 0 && !sender_paused && !sender_idles()) begin
               sample_type s;
               s = pending_samples[0];
               req_valid       <= 1'b1;
               req_first_step  <= s.first_step;
               req_sample_time <= s.sample_time;
               req_lead_value  <= s.lead_value;
               req_aux_zero    <= s.aux[0];
               req_aux_one     <= s.aux[1];
               req_aux_two     <= s.aux[2];
               req_aux_three   <= s.aux[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver backpressure, with a separately counted long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (idle_profile)
            IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 46);
            IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 17);
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: compares each response beat with the oldest expected crossing
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      crossing_type c;
      logic signed [31:0] got_aux [4];
      if (!reset && rsp_valid && rsp_ready) begin
         crossing_beats <= crossing_beats + 1;
         got_aux[0] = rsp_aux_at_cross_zero;
         got_aux[1] = rsp_aux_at_cross_one;
         got_aux[2] = rsp_aux_at_cross_two;
         got_aux[3] = rsp_aux_at_cross_three;
         if (expected_crossings.size() == 0) begin
            failed = 1'b1;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected crossing beat: time %h", rsp_crossing_time);
         end else begin
            c = expected_crossings.pop_front();
            if (rsp_crossing_time !== c.crossing_time
                || rsp_crossing_period !== c.crossing_period
                || got_aux[0] !== c.aux[0] || got_aux[1] !== c.aux[1]
                || got_aux[2] !== c.aux[2] || got_aux[3] !== c.aux[3]) begin
               failed = 1'b1;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("crossing mismatch: exp time %h period %h aux %h %h %h %h",
                     c.crossing_time, c.crossing_period,
                     c.aux[0], c.aux[1], c.aux[2], c.aux[3]);
                  $display("                   got time %h period %h aux %h %h %h %h",
                     rsp_crossing_time, rsp_crossing_period,
                     got_aux[0], got_aux[1], got_aux[2], got_aux[3]);
               end
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > LimitCycles) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   logic [47:0] gen_time;    // running time stamp, which now and then jumps or steps backwards

   function automatic logic [31:0] rand32();
      return $urandom();
   endfunction

   task automatic queue_sample(input logic first, input logic [47:0] t,
                               input logic signed [31:0] lead,
                               input logic signed [31:0] a0, input logic signed [31:0] a1,
                               input logic signed [31:0] a2, input logic signed [31:0] a3);
      sample_type s;
      s.first_step  = first;
      s.sample_time = t;
      s.lead_value  = lead;
      s.aux[0] = a0; s.aux[1] = a1; s.aux[2] = a2; s.aux[3] = a3;
      pending_samples.push_back(s);
   endtask

   // random aux value: full range, or near extremes now and then
   function automatic logic signed [31:0] rand_aux();
      case ($urandom_range(5))
         0:       return 32'sh7fffffff - $urandom_range(3);
         1:       return 32'sh80000000 + $urandom_range(3);
         2:       return $signed(32'($urandom_range(65535))) - 32'sd32768;
         default: return rand32();
      endcase
   endfunction

   function automatic logic [47:0] next_time();
      case ($urandom_range(9))
         0:       gen_time = {rand32(), 16'($urandom())};   // jump, maybe backwards
         1:       gen_time = gen_time;
         2:       gen_time = gen_time - 48'($urandom_range(1000)); // backwards step
         default: gen_time = gen_time + 48'($urandom_range(1 << 24));
      endcase
      return gen_time;
   endfunction

   // lead value placed relative to threshold so crossings are common
   function automatic logic signed [31:0] rand_lead(input logic signed [31:0] thr,
                                                   input bit above);
      logic signed [33:0] v;
      case ($urandom_range(4))
         0: v = above ? 34'sh7fffffff : -34'sh80000000;
         1: v = 34'(thr) + (above ? 34'sd1 : -34'sd1);
         2: v = rand32();
         default: v = 34'(thr) + (above ? 34'($urandom_range(1 << 22)) + 1
                                        : -34'($urandom_range(1 << 22)) - 1);
      endcase
      if (v > 34'sh7fffffff) v = 34'sh7fffffff;
      if (v < -34'sh80000000) v = -34'sh80000000;
      return v[31:0];
   endfunction

   task automatic random_samples(input int count, input logic signed [31:0] thr);
      bit above;
      above = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) above = $urandom_range(1);
         else above = ~above;   // mostly alternating for frequent crossings
         queue_sample($urandom_range(29) == 0, next_time(),
                      ($urandom_range(9) == 0) ? $signed(rand32()) : rand_lead(thr, above),
                      rand_aux(), rand_aux(), rand_aux(), rand_aux());
      end
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_crossings.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      model_threshold   = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic signed [31:0] thr;
      model_threshold = '0;
      hist_time = '0; hist_lead = '0; hist_cross_time = '0;
      for (int i = 0; i < 4; i++) hist_aux[i] = '0;
      gen_time = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset threshold of zero; no crossing from reset history of zero
      queue_sample(1'b0, 48'h000001000000, 32'sh00010000, 32'sh7fffffff,
                   32'sh80000000, 32'sh00001234, -32'sh00001234);
      queue_sample(1'b0, 48'h000002000000, -32'sh00010000, 1, 2, 3, 4);
      // first step with crossing values: history only
      queue_sample(1'b1, 48'h000003000000, 32'sh00020000, 5, 6, 7, 8);
      queue_sample(1'b0, 48'h000003000000, -32'sh80000000, 0, 0, 0, 0);
      // full-scale swing, extreme aux
      queue_sample(1'b0, 48'hffffffffffff, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, -1, 0);
      // time going backwards, crossing earlier than last one
      queue_sample(1'b0, 48'h000000000010, -32'sh00000001, 10, 20, 30, 40);
      queue_sample(1'b0, 48'h000000000000, 32'sh00000001, -10, -20, -30, -40);
      // equal to threshold: no crossing either side
      queue_sample(1'b0, 48'h000000100000, 32'sh00000000, 0, 0, 0, 0);
      queue_sample(1'b0, 48'h000000200000, 32'sh00000005, 0, 0, 0, 0);
      queue_sample(1'b0, 48'h000000300000, -32'sh00000005, 0, 0, 0, 0);
      queue_sample(1'b0, 48'h000000300000, 32'sh00000001, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      wait_drained();

      // extreme thresholds
      write_threshold(32'sh7ffffffe);
      queue_sample(1'b0, 48'h000000400000, 32'sh80000000, 1, 1, 1, 1);
      queue_sample(1'b0, 48'h000000500000, 32'sh7fffffff, 9, 9, 9, 9);
      queue_sample(1'b0, 48'h000000600000, 32'sh80000000, 0, 0, 0, 0);
      wait_drained();
      write_threshold(32'sh80000000);   // nothing is strictly below: no crossings
      queue_sample(1'b0, 48'h000000700000, 32'sh7fffffff, 0, 0, 0, 0);
      queue_sample(1'b0, 48'h000000800000, 32'sh80000000, 0, 0, 0, 0);
      queue_sample(1'b0, 48'h000000900000, 32'sh7fffffff, 0, 0, 0, 0);
      wait_drained();
      write_threshold(32'sh7fffffff);   // nothing is strictly above
      queue_sample(1'b0, 48'h000000a00000, 32'sh7fffffff, 0, 0, 0, 0);
      wait_drained();

      // random phases across threshold settings and idling profiles
      gen_time = 48'h000001000000;
      for (int phase = 0; phase < 8; phase++) begin
         thr = (phase == 0) ? 32'sh80000001 : (phase == 1) ? 32'sh7ffffffe : $signed(rand32());
         if (phase > 3) thr = $signed(32'($urandom_range(1 << 20))) - 32'sd524288;
         write_threshold(thr);
         idle_profile = idle_profile_type'(phase % 4);
         random_samples(150, thr);
         if (phase == 2) begin
            // long receiver hold-off while the sender keeps offering samples
            hold_off_cycles = 600;
         end
         if (phase == 5) begin
            // sender pause until every expected crossing has come
            while (pending_samples.size() > 75) @(posedge clock);
            sender_paused = 1'b1;
            while (req_valid || expected_crossings.size() != 0) @(posedge clock);
            sender_paused = 1'b0;
         end
         wait_drained();
      end

      if (!failed && mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
